// ===== rtl/core/lcar_pkg.sv =====
// Package with the shared types and constants of the load cell reader.
package lcar_pkg;

    localparam int unsigned DATA_PULSES = 24;
    localparam int unsigned KEPT_BITS   = 16;
    localparam logic [2:0]  TARE_READINGS = 3'd5;

    localparam int unsigned PULSE_W = 5;
    localparam int unsigned TICK_W  = 8;
    localparam int unsigned VAL_W   = 16;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    localparam logic signed [15:0] SCALE_RESET = 16'sd179;
    localparam logic [1:0]         EXTRA_RESET = 2'd1;
    localparam logic [7:0]         HALF_RESET  = 8'd2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        REG_EXTRA_PULSES = 2'd0,
        REG_SCALE_COEFF  = 2'd1,
        REG_HALF_PERIOD  = 2'd2
    } t_reg_index;

endpackage

// ===== rtl/core/load_cell_adc_reader_with_tare.sv =====
// Load cell converter reader: serial clock sequencer, filter, tare and force scaling.
//
// Usage: every input item is one tick. It carries the sampled converter data line
// (i_data_level) and a tare request (i_tare_request). For every item the block returns
// exactly one result item: the serial clock level to drive after that tick, a flag that
// marks the tick on which a reading completes, the filtered reading, the scaled force
// and the tare busy flag. Both channels use valid/ready handshakes.
// Timing: an item taken at one edge passes an input register, a state update stage and
// a scaling stage, whose register offers its result. The state update and the one
// 16x17 multiply each take one stage, so an item may be taken every cycle, and a result
// is given every cycle while the receiver keeps i_out_ready high.
// Stall: when i_out_ready is low, the three registers fill and then o_in_ready drops;
// no item is lost or repeated, and the converter timing advances only with items.
// Reset: synchronous, active low. The sequencer goes idle with the clock low, the
// registers take their default values and a tare over five readings is scheduled.
// Configuration: written through the APB port at byte addresses 0, 4 and 8 (extra
// pulses, scale coefficient, half period) while no item is in flight.
module load_cell_adc_reader_with_tare (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_data_level,
    input  logic                          i_tare_request,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_clock_level,
    output logic                          o_sample_valid,
    output logic signed [15:0]            o_filtered_value,
    output logic signed [15:0]            o_force_res,
    output logic                          o_tare_busy,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lcar_pkg::ADDR_W-1:0]   paddr,
    input  logic [lcar_pkg::DATA_W-1:0]   pwdata,
    output logic [lcar_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    // Configuration registers
    logic [1:0]        r_extra;
    logic signed [15:0] r_scale;
    logic [7:0]        r_half;

    // Sequencer and reading state
    lcar_pkg::t_phase                r_phase, n_phase;
    logic [lcar_pkg::PULSE_W-1:0]    r_pulse, n_pulse;
    logic [lcar_pkg::TICK_W-1:0]     r_tick, n_tick;
    logic                            r_clock, n_clock;
    logic [lcar_pkg::VAL_W-1:0]      r_shift, n_shift;
    logic [lcar_pkg::VAL_W-1:0]      r_filt, n_filt;
    logic [lcar_pkg::VAL_W-1:0]      r_offset, n_offset;
    logic signed [15:0]              r_force;
    logic [2:0]                      r_tare_cnt, n_tare_cnt;
    logic                            r_tare_pend, n_tare_pend;
    logic                            n_sample;
    logic signed [16:0]              n_diff;

    // Pipeline registers
    logic               r_s1_valid;
    logic               r_s1_data;
    logic               r_s1_tare;
    logic               r_s2_valid;
    logic               r_s2_clock;
    logic               r_s2_sample;
    logic [15:0]        r_s2_filt;
    logic signed [16:0] r_s2_diff;
    logic               r_s2_busy;
    logic               r_out_valid;
    logic               r_out_clock;
    logic               r_out_sample;
    logic signed [15:0] r_out_filt;
    logic signed [15:0] r_out_force;
    logic               r_out_busy;

    logic en1, en2, en3;
    logic cfg_write;
    logic [7:0] hp;
    logic [lcar_pkg::PULSE_W-1:0] total;
    logic [lcar_pkg::PULSE_W-1:0] pulse_inc;
    logic [15:0] filt_next;

    logic signed [32:0] prod;
    logic signed [32:0] prod_adj;
    logic signed [24:0] quot;
    logic signed [15:0] force_next;

    // Handshake: each stage moves when the stage after it has room.
    assign en3 = !r_out_valid || i_out_ready;
    assign en2 = !r_s2_valid || en3;
    assign en1 = !r_s1_valid || en2;
    assign o_in_ready = en1;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        case (lcar_pkg::t_reg_index'(paddr[3:2]))
            lcar_pkg::REG_EXTRA_PULSES: prdata = {30'd0, r_extra};
            lcar_pkg::REG_SCALE_COEFF:  prdata = {16'd0, r_scale};
            lcar_pkg::REG_HALF_PERIOD:  prdata = {24'd0, r_half};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extra <= lcar_pkg::EXTRA_RESET;
            r_scale <= lcar_pkg::SCALE_RESET;
            r_half  <= lcar_pkg::HALF_RESET;
        end else if (cfg_write) begin
            case (lcar_pkg::t_reg_index'(paddr[3:2]))
                lcar_pkg::REG_EXTRA_PULSES: r_extra <= pwdata[1:0];
                lcar_pkg::REG_SCALE_COEFF:  r_scale <= pwdata[15:0];
                lcar_pkg::REG_HALF_PERIOD:  r_half  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Sequencer next state for the item in the input register
    assign hp        = (r_half == 8'd0) ? 8'd1 : r_half;
    assign total     = lcar_pkg::PULSE_W'(lcar_pkg::DATA_PULSES) + {3'd0, r_extra};
    assign pulse_inc = r_pulse + 1'b1;
    assign filt_next = {r_filt[15], r_filt[15:1]} + {r_shift[15], r_shift[15:1]};

    always_comb begin
        n_phase     = r_phase;
        n_pulse     = r_pulse;
        n_tick      = r_tick;
        n_clock     = r_clock;
        n_shift     = r_shift;
        n_filt      = r_filt;
        n_offset    = r_offset;
        n_tare_cnt  = r_tare_cnt;
        n_tare_pend = r_tare_pend;
        n_sample    = 1'b0;
        n_diff      = 17'(signed'(r_filt)) - 17'(signed'(r_offset));
        case (r_phase)
            lcar_pkg::PH_IDLE: begin
                n_clock = 1'b0;
                if (!r_s1_data) begin
                    n_phase = lcar_pkg::PH_HIGH;
                    n_clock = 1'b1;
                    n_tick  = 8'd1;
                    n_pulse = '0;
                    n_shift = '0;
                end
            end
            lcar_pkg::PH_HIGH: begin
                if (r_tick >= hp) begin
                    n_clock = 1'b0;
                    if (r_pulse < lcar_pkg::PULSE_W'(lcar_pkg::KEPT_BITS)) begin
                        n_shift = {r_shift[14:0], r_s1_data};
                    end
                    n_phase = lcar_pkg::PH_LOW;
                    n_tick  = 8'd1;
                end else begin
                    n_tick = r_tick + 1'b1;
                end
            end
            lcar_pkg::PH_LOW: begin
                if (r_tick >= hp) begin
                    if (pulse_inc < total) begin
                        n_pulse = pulse_inc;
                        n_phase = lcar_pkg::PH_HIGH;
                        n_clock = 1'b1;
                        n_tick  = 8'd1;
                    end else begin
                        n_phase  = lcar_pkg::PH_IDLE;
                        n_clock  = 1'b0;
                        n_tick   = '0;
                        n_pulse  = '0;
                        n_sample = 1'b1;
                        n_filt   = filt_next;
                        // The completing reading is scaled against the old offset.
                        n_diff   = 17'(signed'(filt_next)) - 17'(signed'(r_offset));
                        if (r_tare_pend) begin
                            n_tare_cnt = r_tare_cnt + 1'b1;
                            if (n_tare_cnt >= lcar_pkg::TARE_READINGS) begin
                                n_offset    = filt_next;
                                n_tare_pend = 1'b0;
                                n_tare_cnt  = '0;
                            end
                        end
                    end
                end else begin
                    n_tick = r_tick + 1'b1;
                end
            end
            default: begin
                n_phase = lcar_pkg::PH_IDLE;
                n_clock = 1'b0;
                n_tick  = '0;
                n_pulse = '0;
            end
        endcase
        if (r_s1_tare) begin
            n_tare_pend = 1'b1;
            n_tare_cnt  = '0;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= i_in_valid;
        end
        if (en1) begin
            r_s1_data <= i_data_level;
            r_s1_tare <= i_tare_request;
        end
    end

    // State update, one item per move into the second stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lcar_pkg::PH_IDLE;
            r_pulse     <= '0;
            r_tick      <= '0;
            r_clock     <= 1'b0;
            r_shift     <= '0;
            r_filt      <= '0;
            r_offset    <= '0;
            r_tare_cnt  <= '0;
            r_tare_pend <= 1'b1;
        end else if (r_s1_valid && en2) begin
            r_phase     <= n_phase;
            r_pulse     <= n_pulse;
            r_tick      <= n_tick;
            r_clock     <= n_clock;
            r_shift     <= n_shift;
            r_filt      <= n_filt;
            r_offset    <= n_offset;
            r_tare_cnt  <= n_tare_cnt;
            r_tare_pend <= n_tare_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en2) begin
            r_s2_valid <= r_s1_valid;
        end
        if (en2) begin
            r_s2_clock  <= n_clock;
            r_s2_sample <= n_sample;
            r_s2_filt   <= n_filt;
            r_s2_diff   <= n_diff;
            r_s2_busy   <= n_tare_pend;
        end
    end

    // Force scaling: Q8.8 coefficient times the difference, divided by 256 toward zero, then saturated.
    assign prod     = 33'(r_scale) * 33'(r_s2_diff);
    assign prod_adj = prod + (prod[32] ? 33'sd255 : 33'sd0);
    assign quot     = prod_adj[32:8];

    always_comb begin
        if (quot > 25'sd32767) begin
            force_next = 16'sh7fff;
        end else if (quot < -25'sd32768) begin
            force_next = -16'sh8000;
        end else begin
            force_next = quot[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_force     <= '0;
        end else if (en3) begin
            r_out_valid <= r_s2_valid;
            if (r_s2_valid && r_s2_sample) begin
                r_force <= force_next;
            end
        end
        if (en3) begin
            r_out_clock  <= r_s2_clock;
            r_out_sample <= r_s2_sample;
            r_out_filt   <= r_s2_filt;
            r_out_force  <= r_s2_sample ? force_next : r_force;
            r_out_busy   <= r_s2_busy;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_clock_level    = r_out_clock;
    assign o_sample_valid   = r_out_sample;
    assign o_filtered_value = r_out_filt;
    assign o_force_res      = r_out_force;
    assign o_tare_busy      = r_out_busy;

    // A reading completes only at the end of a low half, so the clock is low then.
    a_sample_clock_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_sample |-> !r_out_clock)
        else $error("reading completed with the serial clock high");

    // The sequencer leaves its counters cleared whenever it is idle.
    a_idle_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == lcar_pkg::PH_IDLE |-> r_tick == '0 && r_pulse == '0)
        else $error("idle sequencer with counters not cleared");

    // An active half always has a running tick count.
    a_active_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != lcar_pkg::PH_IDLE |-> r_tick != '0)
        else $error("active clock half with zero tick count");

    // No tare readings are counted unless a tare is pending.
    a_tare_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_tare_pend |-> r_tare_cnt == '0)
        else $error("tare count nonzero with no tare pending");

endmodule

// ===== test/tb_top.sv =====
// Testbench for the load cell reader: random converter ticks against a tick-by-tick predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic                            i_data_level;
    logic                            i_tare_request;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b1;
    logic                            o_clock_level;
    logic                            o_sample_valid;
    logic signed [15:0]              o_filtered_value;
    logic signed [15:0]              o_force_res;
    logic                            o_tare_busy;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [lcar_pkg::ADDR_W-1:0]     paddr;
    logic [lcar_pkg::DATA_W-1:0]     pwdata;
    logic [lcar_pkg::DATA_W-1:0]     prdata;
    logic                            pready;

    typedef struct {
        logic               clk_lvl;
        logic               done;
        logic signed [15:0] filt;
        logic signed [15:0] force_val;
        logic               busy;
    } t_reader_out;

    t_reader_out reader_outputs_q[$];
    int          mismatches = 0;

    // Predicted converter and register state.
    lcar_pkg::t_phase   ph;
    logic [4:0]         pulses;
    logic [7:0]         ticks;
    logic               clk_lvl;
    logic signed [15:0] shifter;
    logic signed [15:0] filt_acc;
    logic signed [15:0] zero_ofs;
    logic signed [15:0] force_out;
    logic [2:0]         tare_cnt;
    logic               tare_pend;
    logic [1:0]         extra_cfg;
    logic signed [15:0] coeff_cfg;
    logic [7:0]         hp_cfg;

    // Stimulus state: bits of the reading in progress and the sender's burst pacing.
    logic [15:0] reading_bits = 16'h0;
    bit          noisy_reading = 1'b0;
    int          burst_left = 0;

    // Receiver stall pattern state.
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_hold = 0;
    bit rx_toggle = 1'b0;

    load_cell_adc_reader_with_tare dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_level     (i_data_level),
        .i_tare_request   (i_tare_request),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_clock_level    (o_clock_level),
        .o_sample_valid   (o_sample_valid),
        .o_filtered_value (o_filtered_value),
        .o_force_res      (o_force_res),
        .o_tare_busy      (o_tare_busy),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [7:0] effective_half_period();
        return (hp_cfg == 8'd0) ? 8'd1 : hp_cfg;
    endfunction

    // Advances the predicted reader by one tick and queues the result item it gives.
    task automatic step_converter_reader(input logic data, input logic req);
        t_reader_out res;
        logic [7:0]  half;
        int          total;
        int          diff;
        longint      product;
        longint      quotient;
        logic        done;
        half = effective_half_period();
        total = int'(lcar_pkg::DATA_PULSES) + int'(extra_cfg);
        done = 1'b0;
        case (ph)
            lcar_pkg::PH_IDLE: begin
                clk_lvl = 1'b0;
                if (!data) begin
                    ph = lcar_pkg::PH_HIGH;
                    clk_lvl = 1'b1;
                    ticks = 8'd1;
                    pulses = 5'd0;
                    shifter = 16'sd0;
                end
            end
            lcar_pkg::PH_HIGH: begin
                if (ticks >= half) begin
                    clk_lvl = 1'b0;
                    if (pulses < lcar_pkg::KEPT_BITS)
                        shifter = {shifter[14:0], data};
                    ph = lcar_pkg::PH_LOW;
                    ticks = 8'd1;
                end else begin
                    ticks = ticks + 8'd1;
                end
            end
            lcar_pkg::PH_LOW: begin
                if (ticks >= half) begin
                    pulses = pulses + 5'd1;
                    if (int'(pulses) < total) begin
                        ph = lcar_pkg::PH_HIGH;
                        clk_lvl = 1'b1;
                        ticks = 8'd1;
                    end else begin
                        ph = lcar_pkg::PH_IDLE;
                        clk_lvl = 1'b0;
                        ticks = 8'd0;
                        pulses = 5'd0;
                        done = 1'b1;
                        filt_acc = (filt_acc >>> 1) + (shifter >>> 1);
                        diff = int'(filt_acc) - int'(zero_ofs);
                        product = longint'(coeff_cfg) * longint'(diff);
                        // Division truncates toward zero before saturation.
                        quotient = product / 256;
                        if (quotient > 32767)
                            quotient = 32767;
                        if (quotient < -32768)
                            quotient = -32768;
                        force_out = quotient[15:0];
                        // The completing reading still used the old offset above.
                        if (tare_pend) begin
                            tare_cnt = tare_cnt + 3'd1;
                            if (tare_cnt >= lcar_pkg::TARE_READINGS) begin
                                zero_ofs = filt_acc;
                                tare_pend = 1'b0;
                                tare_cnt = 3'd0;
                            end
                        end
                    end
                end else begin
                    ticks = ticks + 8'd1;
                end
            end
            default: begin
                ph = lcar_pkg::PH_IDLE;
                clk_lvl = 1'b0;
                ticks = 8'd0;
                pulses = 5'd0;
            end
        endcase
        if (req) begin
            tare_pend = 1'b1;
            tare_cnt = 3'd0;
        end
        res.clk_lvl = clk_lvl;
        res.done = done;
        res.filt = filt_acc;
        res.force_val = force_out;
        res.busy = tare_pend;
        reader_outputs_q.push_back(res);
    endtask

    // Chooses the next tick so that most conversions carry a planned 16-bit reading.
    task automatic pick_tick(output logic data, output logic req);
        logic [7:0] half;
        bit         completing;
        half = effective_half_period();
        completing = (ph == lcar_pkg::PH_LOW) && (ticks >= half)
            && (int'(pulses) + 1 >= int'(lcar_pkg::DATA_PULSES) + int'(extra_cfg));
        if (ph == lcar_pkg::PH_IDLE) begin
            data = ($urandom_range(0, 3) == 0);
            if (!data) begin
                case ($urandom_range(0, 9))
                    0: reading_bits = 16'h0000;
                    1: reading_bits = 16'hFFFF;
                    2: reading_bits = 16'h7FFF;
                    3: reading_bits = 16'h8000;
                    default: reading_bits = 16'($urandom());
                endcase
                noisy_reading = ($urandom_range(0, 7) == 0);
            end
        end else if (ph == lcar_pkg::PH_HIGH && ticks >= half
                     && pulses < lcar_pkg::KEPT_BITS && !noisy_reading) begin
            data = reading_bits[15 - pulses];
        end else begin
            data = 1'($urandom_range(0, 1));
        end
        if (completing)
            req = ($urandom_range(0, 5) == 0);
        else
            req = ($urandom_range(0, 599) == 0);
    endtask

    // Entered and left at a falling edge.
    task automatic send_tick(input logic data, input logic req);
        int gap;
        i_in_valid <= 1'b1;
        i_data_level <= data;
        i_tare_request <= req;
        do @(posedge i_clk); while (!o_in_ready);
        step_converter_reader(data, req);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0
                : $urandom_range(1, ($urandom_range(0, 9) == 0) ? 12 : 3);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic wait_results_done(input int settle);
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        do begin
            @(negedge i_clk);
            waited++;
        end while (reader_outputs_q.size() != 0 && waited < 20000);
        if (reader_outputs_q.size() != 0) begin
            $display("%0t ns: %0d expected result items never arrived", $time,
                     reader_outputs_q.size());
            mismatches++;
            reader_outputs_q.delete();
        end
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_reg(input lcar_pkg::t_reg_index idx,
                             input logic [lcar_pkg::DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            lcar_pkg::REG_EXTRA_PULSES: extra_cfg = value[1:0];
            lcar_pkg::REG_SCALE_COEFF:  coeff_cfg = value[15:0];
            lcar_pkg::REG_HALF_PERIOD:  hp_cfg = value[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    // Idle ticks with the data line high, and tare requests while no conversion runs.
    task automatic test_idle_ticks();
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
    endtask

    // A long half period is cut short mid-pulse; a zero half period acts as one tick.
    task automatic test_shrinking_half_period();
        wait_results_done(4);
        write_reg(lcar_pkg::REG_HALF_PERIOD, 32'd255);
        write_reg(lcar_pkg::REG_EXTRA_PULSES, 32'd0);
        send_tick(1'b0, 1'b0);
        repeat (10) send_tick(1'($urandom_range(0, 1)), 1'b0);
        wait_results_done(4);
        write_reg(lcar_pkg::REG_HALF_PERIOD, 32'd0);
        repeat (6) send_tick(1'($urandom_range(0, 1)), 1'b0);
    endtask

    task automatic test_random_readings(input logic [1:0] extra, input logic [15:0] coeff,
                                        input logic [7:0] half, input int count);
        logic data;
        logic req;
        wait_results_done(4);
        write_reg(lcar_pkg::REG_EXTRA_PULSES, {30'd0, extra});
        write_reg(lcar_pkg::REG_SCALE_COEFF, {{16{coeff[15]}}, coeff});
        write_reg(lcar_pkg::REG_HALF_PERIOD, {24'd0, half});
        for (int i = 0; i < count; i++) begin
            pick_tick(data, req);
            send_tick(data, req);
            // Let the pipeline drain completely now and then.
            if (i == count / 2 || $urandom_range(0, 399) == 0)
                wait_results_done(0);
        end
    endtask

    // Receiver: runs of always-ready, random ready, long stalls and alternating ready.
    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(50, 300);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            1: i_out_ready <= 1'($urandom_range(0, 1));
            2: begin
                if (rx_hold != 0) begin
                    rx_hold--;
                    i_out_ready <= 1'b0;
                end else if ($urandom_range(0, 7) == 0) begin
                    rx_hold = $urandom_range(1, 20);
                    i_out_ready <= 1'b0;
                end else begin
                    i_out_ready <= 1'b1;
                end
            end
            3: begin
                rx_toggle = ~rx_toggle;
                i_out_ready <= rx_toggle;
            end
            default: i_out_ready <= 1'b1;
        endcase
    end

    function automatic void check_field(string name, int want_v, int got_v);
        if (want_v != got_v) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_reader_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (reader_outputs_q.size() == 0) begin
                $display("%0t ns: result item with nothing expected", $time);
                mismatches++;
            end else begin
                want = reader_outputs_q.pop_front();
                check_field("clock_level", int'(want.clk_lvl), int'(o_clock_level));
                check_field("sample_valid", int'(want.done), int'(o_sample_valid));
                check_field("filtered_value", int'(want.filt), int'(o_filtered_value));
                check_field("force_res", int'(want.force_val), int'(o_force_res));
                check_field("tare_busy", int'(want.busy), int'(o_tare_busy));
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_data_level = 1'b1;
        i_tare_request = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        ph = lcar_pkg::PH_IDLE;
        pulses = 5'd0;
        ticks = 8'd0;
        clk_lvl = 1'b0;
        shifter = 16'sd0;
        filt_acc = 16'sd0;
        zero_ofs = 16'sd0;
        force_out = 16'sd0;
        tare_cnt = 3'd0;
        tare_pend = 1'b1;
        extra_cfg = lcar_pkg::EXTRA_RESET;
        coeff_cfg = lcar_pkg::SCALE_RESET;
        hp_cfg = lcar_pkg::HALF_RESET;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_idle_ticks();
        test_shrinking_half_period();
        test_random_readings(2'd0, 16'h7FFF, 8'd1, 250);
        test_random_readings(2'd3, 16'h8000, 8'd1, 250);
        test_random_readings(2'd1, 16'd179, 8'd2, 200);
        test_random_readings(2'd2, 16'($urandom()), 8'd3, 200);
        test_random_readings(2'd0, 16'hFFFF, 8'd0, 200);
        wait_results_done(8);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== load_cell_adc_reader_with_tare.f =====
rtl/core/lcar_pkg.sv
rtl/core/load_cell_adc_reader_with_tare.sv
test/tb_top.sv
